/* hw/rtl/sfl_pkg.sv */
package sfl_pkg;

  // Default sizes, handed down from the top level
  localparam int unsigned HEAP_WORDS_DEF   = 16384;
  localparam int unsigned SIZE_CLASSES_DEF = 64;

  // Fixed geometry
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned WORD_SHIFT = $clog2(WORD_BYTES);
  localparam int unsigned ADDR_W     = 14;
  localparam int unsigned BYTES_W    = 16;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CLASS_W    = 24;
  localparam int unsigned MARK_W     = DATA_W - CLASS_W;

  localparam logic [CNT_W-1:0]  MAX_REFILL_RST = CNT_W'(128);
  localparam logic [MARK_W-1:0] MARK_BYTE      = MARK_W'(8'h55);

  typedef enum logic {
    KIND_ALLOC,
    KIND_FREE
  } sfl_kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_LARGE,
    ST_EXHAUSTED,
    ST_BAD_FREE
  } sfl_status_e;

  typedef struct packed {
    logic               kind;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_address;
  } sfl_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] user_address;
    logic [1:0]        status;
  } sfl_rsp_t;

  // Datapath actions, one per control word
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_CLEAR,
    ACT_ACCEPT,
    ACT_DECODE,
    ACT_A_LATCH,
    ACT_A_LINK,
    ACT_POP,
    ACT_R_CHECK,
    ACT_CARVE,
    ACT_F_HDR,
    ACT_F_PUSH,
    ACT_RESULT
  } sfl_act_e;

  // Conditions that hold the step counter
  typedef enum logic [2:0] {
    WT_NEVER,
    WT_CLEAR,
    WT_NO_INPUT,
    WT_CARVE,
    WT_OUT_BUSY
  } sfl_wait_e;

  // Conditions that take a jump
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_IS_FREE,
    JC_TOO_LARGE,
    JC_HEAD_ZERO,
    JC_EXHAUST,
    JC_FREE_BAD
  } sfl_jump_e;

  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_CLEAR   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_IDLE    = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_DECODE  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_A_LATCH = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_A_LINK  = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_POP     = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_R_CHECK = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_CARVE   = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_F_HDR   = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_F_PUSH  = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_RESULT  = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_LAST    = STEP_RESULT;

  typedef struct packed {
    sfl_act_e          act;
    sfl_wait_e         wt;
    sfl_jump_e         jc;
    logic [STEP_W-1:0] target;
  } sfl_ctrl_t;

  // Status from the datapath and the channels, seen by the sequencer
  typedef struct packed {
    logic clr_busy;
    logic in_valid;
    logic out_busy;
    logic carve_more;
    logic is_free;
    logic too_large;
    logic head_zero;
    logic exhaust;
    logic free_bad;
  } sfl_flags_t;

  // Control store
  function automatic sfl_ctrl_t sfl_rom(input logic [STEP_W-1:0] step);
    sfl_ctrl_t w;
    unique case (step)
      STEP_CLEAR:   w = '{ACT_CLEAR,   WT_CLEAR,    JC_ALWAYS,    STEP_IDLE};
      STEP_IDLE:    w = '{ACT_ACCEPT,  WT_NO_INPUT, JC_NEVER,     STEP_IDLE};
      STEP_DECODE:  w = '{ACT_DECODE,  WT_NEVER,    JC_IS_FREE,   STEP_F_HDR};
      STEP_A_LATCH: w = '{ACT_A_LATCH, WT_NEVER,    JC_TOO_LARGE, STEP_RESULT};
      STEP_A_LINK:  w = '{ACT_A_LINK,  WT_NEVER,    JC_HEAD_ZERO, STEP_R_CHECK};
      STEP_POP:     w = '{ACT_POP,     WT_NEVER,    JC_ALWAYS,    STEP_RESULT};
      STEP_R_CHECK: w = '{ACT_R_CHECK, WT_NEVER,    JC_EXHAUST,   STEP_RESULT};
      STEP_CARVE:   w = '{ACT_CARVE,   WT_CARVE,    JC_ALWAYS,    STEP_POP};
      STEP_F_HDR:   w = '{ACT_F_HDR,   WT_NEVER,    JC_FREE_BAD,  STEP_RESULT};
      STEP_F_PUSH:  w = '{ACT_F_PUSH,  WT_NEVER,    JC_NEVER,     STEP_RESULT};
      STEP_RESULT:  w = '{ACT_RESULT,  WT_OUT_BUSY, JC_ALWAYS,    STEP_IDLE};
      default:      w = '{ACT_NOP,     WT_NEVER,    JC_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/size_class_free_list_allocator_top.sv */
// Requests: allocate from a non-empty list, allocate with a refill of N blocks (one heap
// write per carved block), free, or an oversize request. One request in flight at a time.
// Each step is one word of the control store acting on the heap and class table RAMs.
// After reset the heap and class table are swept to zero, one word per cycle, across all
// HEAP_WORDS heap words (16384 by default); in_ready_o stays low until then.
module size_class_free_list_allocator_top import sfl_pkg::*; #(
  parameter int unsigned HEAP_WORDS   = HEAP_WORDS_DEF,
  parameter int unsigned SIZE_CLASSES = SIZE_CLASSES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sfl_req_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sfl_rsp_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  sfl_ctrl_t        ctrl;
  sfl_flags_t       flags;
  sfl_rsp_t         rsp;
  logic [CNT_W-1:0] max_refill_q;
  logic             out_valid_q, out_valid_d;
  sfl_rsp_t         out_q;
  logic             out_busy;
  logic             out_load;

  // Refill cap register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_refill_q <= MAX_REFILL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_refill_q <= cfg_data_i;
    end
  end

  // Take a request only at the idle step
  assign in_ready_o = ctrl.act == ACT_ACCEPT;

  // Output register: load a result when the slot is free, drop on transfer
  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = (ctrl.act == ACT_RESULT) && !out_busy;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sfl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  sfl_dp #(
    .HEAP_WORDS   (HEAP_WORDS),
    .SIZE_CLASSES (SIZE_CLASSES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_valid_i   (in_valid_i),
    .req_i        (in_data_i),
    .out_busy_i   (out_busy),
    .max_refill_i (max_refill_q),
    .flags_o      (flags),
    .rsp_o        (rsp)
  );

endmodule

/* hw/rtl/sfl_ram.sv */
module sfl_ram import sfl_pkg::*; #(
  parameter int unsigned WIDTH = DATA_W,
  parameter int unsigned DEPTH = HEAP_WORDS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/sfl_seq.sv */
module sfl_seq import sfl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sfl_flags_t flags_i,
  output sfl_ctrl_t  ctrl_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  sfl_ctrl_t         ctrl;
  logic              wait_hit;
  logic              jump_hit;

  // Fetch the control word
  assign ctrl   = sfl_rom(pc_q);
  assign ctrl_o = ctrl;

  // Evaluate the hold condition
  always_comb begin
    unique case (ctrl.wt)
      WT_NEVER:    wait_hit = 1'b0;
      WT_CLEAR:    wait_hit = flags_i.clr_busy;
      WT_NO_INPUT: wait_hit = !flags_i.in_valid;
      WT_CARVE:    wait_hit = flags_i.carve_more;
      WT_OUT_BUSY: wait_hit = flags_i.out_busy;
      default:     wait_hit = 1'b0;
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (ctrl.jc)
      JC_NEVER:     jump_hit = 1'b0;
      JC_ALWAYS:    jump_hit = 1'b1;
      JC_IS_FREE:   jump_hit = flags_i.is_free;
      JC_TOO_LARGE: jump_hit = flags_i.too_large;
      JC_HEAD_ZERO: jump_hit = flags_i.head_zero;
      JC_EXHAUST:   jump_hit = flags_i.exhaust;
      JC_FREE_BAD:  jump_hit = flags_i.free_bad;
      default:      jump_hit = 1'b0;
    endcase
  end

  // Hold, jump or advance
  always_comb begin
    priority if (wait_hit) begin
      pc_d = pc_q;
    end else if (jump_hit) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* hw/rtl/sfl_dp.sv */
module sfl_dp import sfl_pkg::*; #(
  parameter int unsigned HEAP_WORDS   = HEAP_WORDS_DEF,
  parameter int unsigned SIZE_CLASSES = SIZE_CLASSES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfl_ctrl_t        ctrl_i,
  input  logic             in_valid_i,
  input  sfl_req_t         req_i,
  input  logic             out_busy_i,
  input  logic [CNT_W-1:0] max_refill_i,
  output sfl_flags_t       flags_o,
  output sfl_rsp_t         rsp_o
);

  localparam int unsigned AW   = $clog2(HEAP_WORDS);
  localparam int unsigned PW   = $clog2(HEAP_WORDS + 1);
  localparam int unsigned CLW  = $clog2(SIZE_CLASSES);
  localparam int unsigned TW   = AW + CNT_W;
  localparam int unsigned MULW = CNT_W + CLW;
  localparam int unsigned CMPW = (MULW > PW) ? MULW : PW;
  localparam int unsigned XW   = (ADDR_W > PW) ? ADDR_W : PW;

  // Registers
  sfl_req_t          req_q;
  logic [CLW-1:0]    cls_q;
  logic              too_large_q;
  logic              addr_bad_q;
  logic [AW-1:0]     head_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [AW-1:0]     link_q;
  logic [CNT_W-1:0]  n_q;
  logic [MULW-1:0]   mul_q;
  logic [PW-1:0]     at_q;
  logic [CNT_W-1:0]  left_q;
  logic [PW-1:0]     bump_q;
  logic [AW-1:0]     clr_q;
  sfl_status_e       status_q;
  logic [ADDR_W-1:0] user_q;

  // Memory ports
  logic              heap_we;
  logic [AW-1:0]     heap_waddr;
  logic [DATA_W-1:0] heap_wdata;
  logic [AW-1:0]     heap_raddr;
  logic [DATA_W-1:0] heap_rdata;
  logic              tbl_we;
  logic [CLW-1:0]    tbl_waddr;
  logic [TW-1:0]     tbl_wdata;
  logic [CLW-1:0]    tbl_raddr;
  logic [TW-1:0]     tbl_rdata;

  // Combinational helpers
  logic [BYTES_W-1:0] bytes_m1;
  logic [BYTES_W-1:0] words;
  logic               too_large_c;
  logic [XW-1:0]      hdr_x;
  logic               addr_bad_c;
  logic [AW-1:0]      hdr_idx;
  logic [AW-1:0]      tbl_head;
  logic [CNT_W-1:0]   tbl_cnt;
  logic [AW-1:0]      link_c;
  logic [CLASS_W-1:0] hdr_cls;
  logic               hdr_ok;
  logic [CNT_W-1:0]   cap;
  logic [CNT_W:0]     dbl;
  logic [CNT_W-1:0]   n_c;
  logic [CMPW-1:0]    avail;
  logic               exhaust_c;
  logic [PW-1:0]      at_next;

  // Size class of an allocate request
  assign bytes_m1    = (req_q.request_bytes == '0) ? '0
                     : req_q.request_bytes - BYTES_W'(1);
  assign words       = (bytes_m1 >> WORD_SHIFT) + BYTES_W'(2);
  assign too_large_c = words >= BYTES_W'(SIZE_CLASSES);

  // Header address of a free request
  assign hdr_x      = XW'(req_q.block_address) - XW'(1);
  assign addr_bad_c = (req_q.block_address == '0) || (hdr_x >= XW'(HEAP_WORDS));
  assign hdr_idx    = hdr_x[AW-1:0];

  // Class table entry and heap word views
  assign tbl_head = tbl_rdata[TW-1:CNT_W];
  assign tbl_cnt  = tbl_rdata[CNT_W-1:0];
  assign link_c   = (heap_rdata < DATA_W'(HEAP_WORDS)) ? heap_rdata[AW-1:0] : '0;
  assign hdr_cls  = heap_rdata[CLASS_W-1:0];
  assign hdr_ok   = (heap_rdata[DATA_W-1:CLASS_W] == MARK_BYTE)
                 && (hdr_cls >= CLASS_W'(2))
                 && (hdr_cls < CLASS_W'(SIZE_CLASSES));

  // Refill size: double the last count, start at one, cap at the register
  assign cap = (max_refill_i == '0) ? CNT_W'(1) : max_refill_i;
  assign dbl = (tbl_cnt == '0) ? (CNT_W + 1)'(1) : {tbl_cnt, 1'b0};
  assign n_c = (dbl > {1'b0, cap}) ? cap : dbl[CNT_W-1:0];

  // Room left above the bump pointer
  assign avail     = CMPW'(HEAP_WORDS) - CMPW'(bump_q);
  assign exhaust_c = CMPW'(mul_q) > avail;
  assign at_next   = at_q + PW'(cls_q);

  // Memory port selection
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = hdr_idx;
    heap_wdata = '0;
    tbl_we     = 1'b0;
    tbl_waddr  = cls_q;
    tbl_wdata  = '0;
    heap_raddr = (ctrl_i.act == ACT_A_LATCH) ? tbl_head : hdr_idx;
    tbl_raddr  = (ctrl_i.act == ACT_F_HDR) ? hdr_cls[CLW-1:0] : words[CLW-1:0];
    unique case (ctrl_i.act)
      ACT_CLEAR: begin
        heap_we    = 1'b1;
        heap_waddr = clr_q;
        tbl_we     = PW'(clr_q) < PW'(SIZE_CLASSES);
        tbl_waddr  = clr_q[CLW-1:0];
      end
      ACT_CARVE: begin
        heap_we    = 1'b1;
        heap_waddr = at_q[AW-1:0];
        heap_wdata = (left_q != CNT_W'(1)) ? DATA_W'(at_next) : '0;
      end
      ACT_POP: begin
        heap_we    = 1'b1;
        heap_waddr = head_q;
        heap_wdata = {MARK_BYTE, CLASS_W'(cls_q)};
        tbl_we     = 1'b1;
        tbl_wdata  = {link_q, cnt_q};
      end
      ACT_F_PUSH: begin
        heap_we    = 1'b1;
        heap_wdata = DATA_W'(tbl_head);
        tbl_we     = 1'b1;
        tbl_wdata  = {hdr_idx, tbl_cnt};
      end
      default: begin
      end
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.act)
      ACT_ACCEPT: begin
        if (in_valid_i) begin
          req_q <= req_i;
        end
      end
      ACT_DECODE: begin
        cls_q       <= words[CLW-1:0];
        too_large_q <= too_large_c;
        addr_bad_q  <= addr_bad_c;
        status_q    <= ST_OK;
        user_q      <= '0;
      end
      ACT_A_LATCH: begin
        head_q <= tbl_head;
        cnt_q  <= tbl_cnt;
        n_q    <= n_c;
        mul_q  <= MULW'(n_c) * MULW'(cls_q);
        if (too_large_q) begin
          status_q <= ST_TOO_LARGE;
        end
      end
      ACT_A_LINK: begin
        link_q <= link_c;
      end
      ACT_R_CHECK: begin
        if (exhaust_c) begin
          status_q <= ST_EXHAUSTED;
        end else begin
          at_q   <= bump_q;
          left_q <= n_q;
          head_q <= bump_q[AW-1:0];
          cnt_q  <= n_q;
          link_q <= (n_q != CNT_W'(1)) ? AW'(bump_q + PW'(cls_q)) : '0;
        end
      end
      ACT_CARVE: begin
        at_q   <= at_next;
        left_q <= left_q - CNT_W'(1);
      end
      ACT_POP: begin
        status_q <= ST_OK;
        user_q   <= ADDR_W'(PW'(head_q) + PW'(1));
      end
      ACT_F_HDR: begin
        cls_q <= hdr_cls[CLW-1:0];
        if (addr_bad_q || !hdr_ok) begin
          status_q <= ST_BAD_FREE;
        end
      end
      default: begin
      end
    endcase
  end

  // Bump pointer and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q <= PW'(1);
      clr_q  <= '0;
    end else begin
      if (ctrl_i.act == ACT_R_CHECK && !exhaust_c) begin
        bump_q <= bump_q + PW'(mul_q);
      end
      if (ctrl_i.act == ACT_CLEAR && flags_o.clr_busy) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  sfl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (HEAP_WORDS)
  ) u_heap (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  sfl_ram #(
    .WIDTH (TW),
    .DEPTH (SIZE_CLASSES)
  ) u_class_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Status toward the sequencer
  assign flags_o.clr_busy   = clr_q != AW'(HEAP_WORDS - 1);
  assign flags_o.in_valid   = in_valid_i;
  assign flags_o.out_busy   = out_busy_i;
  assign flags_o.carve_more = left_q != CNT_W'(1);
  assign flags_o.is_free    = req_q.kind == KIND_FREE;
  assign flags_o.too_large  = too_large_q;
  assign flags_o.head_zero  = head_q == '0;
  assign flags_o.exhaust    = exhaust_c;
  assign flags_o.free_bad   = addr_bad_q || !hdr_ok;

  assign rsp_o.user_address = user_q;
  assign rsp_o.status       = status_q;

  // Checks
  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= PW'(HEAP_WORDS))
    else $error("bump pointer beyond heap");

  a_bump_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q >= $past(bump_q))
    else $error("bump pointer moved back");

  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.act == ACT_POP |-> head_q != '0 && cls_q >= CLW'(2))
    else $error("pop of null head or bad class");

  a_carve_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.act == ACT_CARVE |-> left_q != '0)
    else $error("carve with no blocks left");

endmodule

/* verif/size_class_free_list_allocator_top_tb.sv */
module size_class_free_list_allocator_top_tb;
  import sfl_pkg::*;

  localparam int unsigned HEAP_N       = HEAP_WORDS_DEF;
  localparam int unsigned CLASS_N      = SIZE_CLASSES_DEF;
  localparam int unsigned MIN_CLASS    = 2;
  localparam int unsigned BUMP_W       = ADDR_W + 1;
  localparam int unsigned PHASE_ITEMS  = 255;
  localparam int unsigned FREED_KEEP   = 32;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_LINES = 200;
  // The longest quiet stretches are the reset sweep and a refill of 2047 blocks;
  // allow several times the worst of these.
  localparam int unsigned QUIET_LIMIT  = 100000;

  // Predicts allocator replies and checks them in order
  class alloc_scoreboard;
    bit [DATA_W-1:0] heap_mem [HEAP_N];
    bit [ADDR_W-1:0] list_head [CLASS_N];
    bit [CNT_W-1:0]  refill_cnt [CLASS_N];
    bit [BUMP_W-1:0] bump_ptr = BUMP_W'(1);
    bit [CNT_W-1:0]  refill_cap = MAX_REFILL_RST;
    sfl_rsp_t        expected_replies [$];
    int unsigned     mismatches;

    function void set_refill_cap(bit [CNT_W-1:0] value);
      refill_cap = value;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function sfl_rsp_t predict_alloc(bit [BYTES_W-1:0] bytes);
      sfl_rsp_t    rsp;
      int unsigned words, cap, blocks, base, at, head, link, k;
      rsp = '0;
      words = (bytes == '0) ? 2 : (32'(bytes) - 1) / WORD_BYTES + 2;
      if (words >= CLASS_N) begin
        rsp.status = ST_TOO_LARGE;
        return rsp;
      end
      // Empty list: double the refill run, cap it, carve from the bump region
      if (list_head[words] == '0) begin
        cap = (refill_cap == '0) ? 1 : refill_cap;
        blocks = (refill_cnt[words] == '0) ? 1 : 2 * refill_cnt[words];
        if (blocks > cap) blocks = cap;
        base = bump_ptr;
        if (base > HEAP_N || blocks * words > HEAP_N - base) begin
          rsp.status = ST_EXHAUSTED;
          return rsp;
        end
        refill_cnt[words] = CNT_W'(blocks);
        for (k = 0; k < blocks; k++) begin
          at = base + k * words;
          heap_mem[at] = (k + 1 < blocks) ? DATA_W'(at + words) : '0;
        end
        bump_ptr = BUMP_W'(base + blocks * words);
        list_head[words] = ADDR_W'(base);
      end
      head = list_head[words];
      if (head == 0 || head >= HEAP_N) begin
        rsp.status = ST_EXHAUSTED;
        return rsp;
      end
      // Pop the head; a link past the heap reads as null
      link = heap_mem[head];
      list_head[words] = (link < HEAP_N) ? ADDR_W'(link) : '0;
      heap_mem[head] = {MARK_BYTE, CLASS_W'(words)};
      rsp.user_address = ADDR_W'(head + 1);
      rsp.status = ST_OK;
      return rsp;
    endfunction

    function sfl_rsp_t predict_free(bit [ADDR_W-1:0] user);
      sfl_rsp_t        rsp;
      int unsigned     hdr, cls;
      bit [DATA_W-1:0] word;
      rsp = '0;
      rsp.status = ST_BAD_FREE;
      if (user == '0) return rsp;
      hdr = user - 1;
      if (hdr >= HEAP_N) return rsp;
      word = heap_mem[hdr];
      if (word[DATA_W-1:CLASS_W] != MARK_BYTE) return rsp;
      cls = word[CLASS_W-1:0];
      if (cls < MIN_CLASS || cls >= CLASS_N) return rsp;
      // Push the block back on its class list
      heap_mem[hdr] = DATA_W'(list_head[cls]);
      list_head[cls] = ADDR_W'(hdr);
      rsp.status = ST_OK;
      return rsp;
    endfunction

    function sfl_rsp_t note_request(sfl_req_t req);
      sfl_rsp_t rsp;
      if (req.kind == KIND_FREE) rsp = predict_free(req.block_address);
      else rsp = predict_alloc(req.request_bytes);
      expected_replies.push_back(rsp);
      return rsp;
    endfunction

    task report(string msg);
      if (mismatches < REPORT_LINES) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_reply(sfl_rsp_t got);
      sfl_rsp_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply with none pending: user_address=%0d status=%0d",
                         got.user_address, got.status));
        return;
      end
      want = expected_replies.pop_front();
      if (got.user_address !== want.user_address)
        report($sformatf("user_address got %0d want %0d", got.user_address,
                         want.user_address));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid_q = 1'b0;
  sfl_req_t          in_data_q = '0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready_q = 1'b0;
  sfl_rsp_t          out_data;
  logic              cfg_valid_q = 1'b0;
  logic [CNT_W-1:0]  cfg_data_q = '0;
  logic              cfg_ready;
  int                stall_pct = 0;
  int unsigned       quiet_cycles = 0;
  alloc_scoreboard   sb;
  logic [ADDR_W-1:0] live_q [$];
  logic [ADDR_W-1:0] freed_q [$];

  size_class_free_list_allocator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data_q),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready_q),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data_q)
  );

  always #4 clk = ~clk;

  // Stall the reply channel at the phase's rate
  always @(posedge clk) begin
    out_ready_q <= ($urandom_range(99) >= stall_pct);
  end

  // Check every reply transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready_q) sb.check_reply(out_data);
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_valid_q && in_ready) || (out_valid && out_ready_q) || (cfg_valid_q && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("size_class_free_list_allocator_top test failed");
      $finish;
    end
  end

  function automatic sfl_req_t make_req(sfl_kind_e kind, logic [BYTES_W-1:0] bytes,
                                        logic [ADDR_W-1:0] addr);
    sfl_req_t r;
    r.kind = kind;
    r.request_bytes = bytes;
    r.block_address = addr;
    return r;
  endfunction

  // Offer one request, hold it until the transfer, then track live blocks
  task automatic send_request(sfl_req_t req);
    sfl_rsp_t predicted;
    int       hit [$];
    in_valid_q <= 1'b1;
    in_data_q  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = sb.note_request(req);
    if (predicted.status == ST_OK) begin
      if (req.kind == KIND_ALLOC) begin
        live_q.push_back(predicted.user_address);
        hit = freed_q.find_first_index with (item == predicted.user_address);
        if (hit.size() != 0) freed_q.delete(hit[0]);
      end else begin
        hit = live_q.find_first_index with (item == req.block_address);
        if (hit.size() != 0) live_q.delete(hit[0]);
        freed_q.push_back(req.block_address);
        if (freed_q.size() > FREED_KEEP) void'(freed_q.pop_front());
      end
    end
  endtask

  // Wait for every pending reply, then let the block settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One phase: write the refill cap, then random alloc/free traffic
  task automatic run_phase(logic [CNT_W-1:0] cap, int unsigned idle_pct, int stall,
                           int unsigned alloc_pct, int unsigned big_pct);
    sfl_req_t    req;
    int unsigned pick, sel, n;
    cfg_valid_q <= 1'b1;
    cfg_data_q  <= cap;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid_q <= 1'b0;
    sb.set_refill_cap(cap);
    stall_pct <= stall;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(99) < idle_pct) begin
        in_valid_q <= 1'b0;
        repeat ($urandom_range(4, 1)) @(posedge clk);
      end
      req = make_req(KIND_ALLOC, BYTES_W'($urandom), ADDR_W'($urandom));
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        // Mostly small classes, some large, a few oversize
        sel = $urandom_range(99);
        if (sel < big_pct) req.request_bytes = BYTES_W'($urandom_range(248, 180));
        else begin
          sel = $urandom_range(99);
          if (sel < 70) req.request_bytes = BYTES_W'($urandom_range(32));
          else if (sel < 90) req.request_bytes = BYTES_W'($urandom_range(248));
          else if (sel < 95) req.request_bytes = BYTES_W'($urandom_range(300, 249));
        end
      end else if (pick < 85 && live_q.size() != 0) begin
        req.kind = KIND_FREE;
        req.block_address = live_q[$urandom_range(live_q.size() - 1)];
      end else begin
        // Broken frees: repeats, null, interior words, or any address
        req.kind = KIND_FREE;
        sel = $urandom_range(3);
        if (sel == 0 && freed_q.size() != 0)
          req.block_address = freed_q[$urandom_range(freed_q.size() - 1)];
        else if (sel == 1)
          req.block_address = '0;
        else if (sel == 2 && live_q.size() != 0)
          req.block_address = live_q[$urandom_range(live_q.size() - 1)] + 1'b1;
      end
      send_request(req);
    end
    in_valid_q <= 1'b0;
    drain();
  endtask

  initial begin
    logic [ADDR_W-1:0] first_blk;
    logic [ADDR_W-1:0] top_blk;
    sb = new;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest classes: first refill, doubled refill, pop
    send_request(make_req(KIND_ALLOC, 16'd0, '1));
    first_blk = live_q[0];
    send_request(make_req(KIND_ALLOC, 16'd1, '0));
    send_request(make_req(KIND_ALLOC, 16'd4, '0));
    send_request(make_req(KIND_ALLOC, 16'd5, '0));
    // Largest class, one past it, and the widest request
    send_request(make_req(KIND_ALLOC, 16'd248, '0));
    top_blk = live_q[live_q.size() - 1];
    send_request(make_req(KIND_ALLOC, 16'd249, '0));
    send_request(make_req(KIND_ALLOC, 16'hFFFF, '1));
    // Free, free again, then take the block back
    send_request(make_req(KIND_FREE, 16'hFFFF, first_blk));
    send_request(make_req(KIND_FREE, 16'h0000, first_blk));
    send_request(make_req(KIND_ALLOC, 16'd3, '0));
    // Bad frees: null, header at word 0, untouched words, a user word
    send_request(make_req(KIND_FREE, '0, '0));
    send_request(make_req(KIND_FREE, '0, 14'd1));
    send_request(make_req(KIND_FREE, '0, 14'h3FFF));
    send_request(make_req(KIND_FREE, '0, 14'h2AAA));
    send_request(make_req(KIND_FREE, '0, 14'h1555));
    send_request(make_req(KIND_FREE, '0, first_blk + 1'b1));
    // Cycle the largest class through its list and a second refill
    send_request(make_req(KIND_FREE, '0, top_blk));
    send_request(make_req(KIND_ALLOC, 16'd248, '0));
    send_request(make_req(KIND_ALLOC, 16'd245, '0));
    send_request(make_req(KIND_FREE, '0, top_blk));
    in_valid_q <= 1'b0;
    drain();

    run_phase(11'd0,    0,  0,  55, 5);
    run_phase(11'd1,    66, 0,  50, 5);
    run_phase(11'd2047, 0,  66, 85, 60);
    run_phase(11'd1024, 34, 34, 50, 5);
    run_phase(11'd3,    0,  0,  50, 10);
    run_phase(11'd128,  66, 0,  45, 5);

    if (sb.mismatches == 0)
      $display("size_class_free_list_allocator_top test passed");
    else
      $display("size_class_free_list_allocator_top test failed");
    $finish;
  end

endmodule
